/* src/chgw_pkg.sv */
// Shared types and constants for the gift-wrap convex hull unit.
// Holds the controller/datapath command and status structs and default sizes.
// No dependencies; compile first.
package chgw_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [1:0] {
        PT_SCAN = 2'd0,
        PT_A    = 2'd1,
        PT_B    = 2'd2
    } t_ptsel;

    typedef enum logic [1:0] {
        MUL_CA = 2'd0,
        MUL_CB = 2'd1,
        MUL_SX = 2'd2,
        MUL_SY = 2'd3
    } t_mul;

    typedef struct packed {
        logic   in_rdy;
        logic   pt_rd;
        t_ptsel pt_sel;
        logic   srch_cmp;
        logic   vtx_rec;
        logic   diff;
        logic   mul_en;
        t_mul   mul_sel;
        logic   decide;
        logic   wrap;
        logic   hl_rd;
        logic   hl_next;
        logic   lat_a;
        logic   lat_b;
        logic   lat_pa;
        logic   emit;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic scan_last;
        logic done;
        logic out_free;
        logic k_last;
    } t_status;

endpackage

/* src/chgw_if.sv */
// Handshake interfaces for the point input channel and the hull vertex output channel.
// Depends on chgw_pkg for default widths.
interface chgw_point_if #(
    parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface chgw_vertex_if #(
    parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF,
    parameter int IDX_BITS   = $clog2(chgw_pkg::MAX_POINTS_DEF)
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic [IDX_BITS-1:0]          point_index;
    logic signed [COORD_BITS:0]   normal_x;
    logic signed [COORD_BITS:0]   normal_y;
    logic                         capped;
    logic                         last_vertex;

    modport source (output valid, vertex_x, vertex_y, point_index, normal_x, normal_y,
                    capped, last_vertex, input ready);
    modport sink (input valid, vertex_x, vertex_y, point_index, normal_x, normal_y,
                  capped, last_vertex, output ready);
endinterface

/* src/convex_hull_gift_wrap_unit.sv */
// Top level of the gift-wrap convex hull unit: controller plus datapath.
// Depends on chgw_pkg, chgw_if, chgw_ctrl and chgw_dpath.
//
//   Port      Dir  Payload                                          Item
//   i_point   in   point_x, point_y, last_point                     one point
//   o_vertex  out  vertex_x, vertex_y, point_index, normal_x,       one hull vertex
//                  normal_y, capped, last_vertex
//
// A point without last_point is stored while the memory has room. The last point
// starts the hull: a scan of all points finds the start point, then each of the h
// hull vertices takes a further scan, in which one shared multiplier forms four
// products per scanned point. The vertices then leave one at a time when o_vertex
// is ready; i_point.ready stays low from the last point until the final vertex is
// loaded into the output register.
// Reset is synchronous and active low; the point memory needs no clearing.
module convex_hull_gift_wrap_unit #(
    parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    chgw_point_if.sink    i_point,
    chgw_vertex_if.source o_vertex
);

    chgw_pkg::t_cmd    w_cmd;
    chgw_pkg::t_status w_status;

    chgw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    chgw_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_point  (i_point),
        .o_vertex (o_vertex)
    );

endmodule

/* src/chgw_ctrl.sv */
// Sequencing state machine of the gift-wrap convex hull unit.
// Depends on chgw_pkg for the command and status structs.
module chgw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chgw_pkg::t_status i_status,
    output chgw_pkg::t_cmd    o_cmd
);

    typedef enum logic [16:0] {
        ST_LOAD = 17'h00001,
        ST_SRD  = 17'h00002,
        ST_SCMP = 17'h00004,
        ST_VTX  = 17'h00008,
        ST_RD   = 17'h00010,
        ST_DIFF = 17'h00020,
        ST_M0   = 17'h00040,
        ST_M1   = 17'h00080,
        ST_M2   = 17'h00100,
        ST_M3   = 17'h00200,
        ST_DEC  = 17'h00400,
        ST_NEXT = 17'h00800,
        ST_HA   = 17'h01000,
        ST_HB   = 17'h02000,
        ST_PA   = 17'h04000,
        ST_PB   = 17'h08000,
        ST_OUT  = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.pt_sel   = chgw_pkg::PT_SCAN;
        o_cmd.mul_sel  = chgw_pkg::MUL_CA;
        unique case (r_state)
            ST_LOAD: begin
                o_cmd.in_rdy = 1'b1;
                if (i_status.in_fire && i_status.in_last) begin
                    n_state = ST_SRD;
                end
            end
            ST_SRD: begin
                o_cmd.pt_rd = 1'b1;
                n_state     = ST_SCMP;
            end
            ST_SCMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = i_status.scan_last ? ST_VTX : ST_SRD;
            end
            ST_VTX: begin
                o_cmd.vtx_rec = 1'b1;
                n_state       = ST_RD;
            end
            ST_RD: begin
                o_cmd.pt_rd = 1'b1;
                n_state     = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_M0;
            end
            ST_M0: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_M1;
            end
            ST_M1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = chgw_pkg::MUL_CB;
                n_state       = ST_M2;
            end
            ST_M2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = chgw_pkg::MUL_SX;
                n_state       = ST_M3;
            end
            ST_M3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = chgw_pkg::MUL_SY;
                n_state       = ST_DEC;
            end
            ST_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = i_status.scan_last ? ST_NEXT : ST_RD;
            end
            ST_NEXT: begin
                o_cmd.wrap = 1'b1;
                n_state    = i_status.done ? ST_HA : ST_VTX;
            end
            ST_HA: begin
                o_cmd.hl_rd = 1'b1;
                n_state     = ST_HB;
            end
            ST_HB: begin
                o_cmd.hl_rd   = 1'b1;
                o_cmd.hl_next = 1'b1;
                o_cmd.lat_a   = 1'b1;
                n_state       = ST_PA;
            end
            ST_PA: begin
                o_cmd.lat_b  = 1'b1;
                o_cmd.pt_rd  = 1'b1;
                o_cmd.pt_sel = chgw_pkg::PT_A;
                n_state      = ST_PB;
            end
            ST_PB: begin
                o_cmd.lat_pa = 1'b1;
                o_cmd.pt_rd  = 1'b1;
                o_cmd.pt_sel = chgw_pkg::PT_B;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.emit = 1'b1;
                if (i_status.out_free) begin
                    n_state = i_status.k_last ? ST_LOAD : ST_HA;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

/* src/chgw_dpath.sv */
// Datapath of the gift-wrap convex hull unit: point and hull memories, shared
// multiplier, candidate selection and the output register.
// Depends on chgw_pkg and the chgw_point_if / chgw_vertex_if interfaces.
module chgw_dpath #(
    parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chgw_pkg::t_cmd    i_cmd,
    output chgw_pkg::t_status o_status,
    chgw_point_if.sink        i_point,
    chgw_vertex_if.source     o_vertex
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int DIF_W = COORD_BITS + 1;
    localparam int PRD_W = 2 * DIF_W;
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int LEN_W = SQ_W + 1;
    localparam int CRS_W = PRD_W + 1;
    localparam int PT_W  = 2 * COORD_BITS;

    logic [PT_W-1:0]  r_mem [MAX_POINTS];
    logic [PT_W-1:0]  r_rd;
    logic [IDX_W-1:0] r_hull [MAX_POINTS];
    logic [IDX_W-1:0] r_hrd;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_emit;
    logic [IDX_W-1:0] r_scan;
    logic [IDX_W-1:0] r_start;
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] r_cand;
    logic             r_cand_ok;
    logic [IDX_W-1:0] r_k;
    logic             r_ovalid;

    logic signed [COORD_BITS-1:0] r_sx, r_sy;
    logic signed [COORD_BITS-1:0] r_cx, r_cy;
    logic signed [COORD_BITS-1:0] r_kx, r_ky;
    logic signed [COORD_BITS-1:0] r_ax, r_ay;
    logic [LEN_W-1:0]             r_len;
    logic signed [DIF_W-1:0]      r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [PRD_W-1:0]      r_pa, r_pb;
    logic [SQ_W-1:0]              r_sqx, r_sqy;
    logic                         r_capped;
    logic [IDX_W-1:0]             r_a, r_b;

    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic                         in_fire;
    logic                         full;
    logic                         scan_last;
    logic                         k_last;
    logic                         out_free;
    logic                         out_load;
    logic                         srch_take;
    logic                         take;
    logic [IDX_W-1:0]             scan_next;
    logic [IDX_W-1:0]             k_next;
    logic [IDX_W-1:0]             pt_addr;
    logic [IDX_W-1:0]             hl_addr;
    logic signed [DIF_W-1:0]      mul_a, mul_b;
    logic signed [PRD_W-1:0]      prod;
    logic signed [CRS_W-1:0]      crs;
    logic [LEN_W-1:0]             len;

    assign rd_x = r_rd[COORD_BITS-1:0];
    assign rd_y = r_rd[PT_W-1:COORD_BITS];

    assign i_point.ready = i_cmd.in_rdy;
    assign in_fire       = i_point.valid && i_cmd.in_rdy;
    assign full          = (r_count == CNT_W'(MAX_POINTS));
    assign scan_next     = r_scan + IDX_W'(1);
    assign k_next        = r_k + IDX_W'(1);
    assign scan_last     = ((CNT_W'(r_scan) + CNT_W'(1)) == r_count);
    assign k_last        = ((CNT_W'(r_k) + CNT_W'(1)) == r_emit);
    assign out_free      = !r_ovalid || o_vertex.ready;
    assign out_load      = i_cmd.emit && out_free;

    assign srch_take = (r_scan == '0) || (rd_x > r_sx) || ((rd_x == r_sx) && (rd_y < r_sy));

    assign crs  = {r_pa[PRD_W-1], r_pa} - {r_pb[PRD_W-1], r_pb};
    assign len  = LEN_W'(r_sqx) + LEN_W'(r_sqy);
    assign take = !r_cand_ok || (r_cand == r_cur) || crs[CRS_W-1]
                  || ((r_pa == r_pb) && (len > r_len));

    assign o_status.in_fire   = in_fire;
    assign o_status.in_last   = i_point.last_point;
    assign o_status.scan_last = scan_last;
    assign o_status.done      = (r_cand == r_start) || (r_emit == CNT_W'(MAX_POINTS));
    assign o_status.out_free  = out_free;
    assign o_status.k_last    = k_last;

    always_comb begin
        case (i_cmd.pt_sel)
            chgw_pkg::PT_A: pt_addr = r_a;
            chgw_pkg::PT_B: pt_addr = r_b;
            default:        pt_addr = r_scan;
        endcase
    end

    assign hl_addr = i_cmd.hl_next ? (k_last ? '0 : k_next) : r_k;

    always_comb begin
        case (i_cmd.mul_sel)
            chgw_pkg::MUL_CA: begin
                mul_a = r_e1x;
                mul_b = r_e2y;
            end
            chgw_pkg::MUL_CB: begin
                mul_a = r_e1y;
                mul_b = r_e2x;
            end
            chgw_pkg::MUL_SX: begin
                mul_a = r_e2x;
                mul_b = r_e2x;
            end
            default: begin
                mul_a = r_e2y;
                mul_b = r_e2y;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (in_fire && !full) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_point.point_y, i_point.point_x};
        end
        if (i_cmd.pt_rd) begin
            r_rd <= r_mem[pt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_rec) begin
            r_hull[r_emit[IDX_W-1:0]] <= r_cur;
        end
        if (i_cmd.hl_rd) begin
            r_hrd <= r_hull[hl_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_emit    <= '0;
            r_scan    <= '0;
            r_start   <= '0;
            r_cur     <= '0;
            r_cand    <= '0;
            r_cand_ok <= 1'b0;
            r_k       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (in_fire) begin
                if (!full) begin
                    r_count <= r_count + CNT_W'(1);
                end
                if (i_point.last_point) begin
                    r_scan  <= '0;
                    r_start <= '0;
                end
            end
            if (i_cmd.srch_cmp) begin
                r_scan <= scan_next;
                if (srch_take) begin
                    r_start <= r_scan;
                end
                if (scan_last) begin
                    r_cur  <= srch_take ? r_scan : r_start;
                    r_emit <= '0;
                end
            end
            if (i_cmd.vtx_rec) begin
                r_emit    <= r_emit + CNT_W'(1);
                r_scan    <= '0;
                r_cand_ok <= 1'b0;
            end
            if (i_cmd.decide) begin
                r_scan <= scan_next;
                if (take) begin
                    r_cand    <= r_scan;
                    r_cand_ok <= 1'b1;
                end
            end
            if (i_cmd.wrap) begin
                r_cur <= r_cand;
                r_k   <= '0;
            end
            if (out_load) begin
                r_k <= k_next;
                if (k_last) begin
                    r_count <= '0;
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_vertex.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_cmp) begin
            if (srch_take) begin
                r_sx <= rd_x;
                r_sy <= rd_y;
            end
            if (scan_last) begin
                r_cx <= srch_take ? rd_x : r_sx;
                r_cy <= srch_take ? rd_y : r_sy;
            end
        end
        if (i_cmd.diff) begin
            r_e1x <= {r_kx[COORD_BITS-1], r_kx} - {r_cx[COORD_BITS-1], r_cx};
            r_e1y <= {r_ky[COORD_BITS-1], r_ky} - {r_cy[COORD_BITS-1], r_cy};
            r_e2x <= {rd_x[COORD_BITS-1], rd_x} - {r_cx[COORD_BITS-1], r_cx};
            r_e2y <= {rd_y[COORD_BITS-1], rd_y} - {r_cy[COORD_BITS-1], r_cy};
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                chgw_pkg::MUL_CA: r_pa  <= prod;
                chgw_pkg::MUL_CB: r_pb  <= prod;
                chgw_pkg::MUL_SX: r_sqx <= prod[SQ_W-1:0];
                default:          r_sqy <= prod[SQ_W-1:0];
            endcase
        end
        if (i_cmd.decide && take) begin
            r_kx  <= rd_x;
            r_ky  <= rd_y;
            r_len <= len;
        end
        if (i_cmd.wrap) begin
            r_cx     <= r_kx;
            r_cy     <= r_ky;
            r_capped <= (r_cand != r_start);
        end
        if (i_cmd.lat_a) begin
            r_a <= r_hrd;
        end
        if (i_cmd.lat_b) begin
            r_b <= r_hrd;
        end
        if (i_cmd.lat_pa) begin
            r_ax <= rd_x;
            r_ay <= rd_y;
        end
        if (out_load) begin
            o_vertex.vertex_x    <= r_ax;
            o_vertex.vertex_y    <= r_ay;
            o_vertex.point_index <= r_a;
            o_vertex.normal_x    <= {rd_y[COORD_BITS-1], rd_y} - {r_ay[COORD_BITS-1], r_ay};
            o_vertex.normal_y    <= {r_ax[COORD_BITS-1], r_ax} - {rd_x[COORD_BITS-1], rd_x};
            o_vertex.capped      <= r_capped;
            o_vertex.last_vertex <= k_last;
        end
    end

    assign o_vertex.valid = r_ovalid;

endmodule
